[rtl/xdec_pkg.sv]
// Package for the 8086 instruction decoder: record types, opcode class codes
// and the opcode classification function shared by the front and back ends.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xdec_pkg;

	// op_kind codes
	localparam logic [2:0] KIND_MOV     = 3'd0;
	localparam logic [2:0] KIND_ADD     = 3'd1;
	localparam logic [2:0] KIND_SUB     = 3'd2;
	localparam logic [2:0] KIND_CMP     = 3'd3;
	localparam logic [2:0] KIND_JCC     = 3'd4;
	localparam logic [2:0] KIND_LOOP    = 3'd5;
	localparam logic [2:0] KIND_GRP1    = 3'd6;
	localparam logic [2:0] KIND_UNKNOWN = 3'd7;

	// form codes
	localparam logic [2:0] FORM_RM_REG  = 3'd0;
	localparam logic [2:0] FORM_IMM_REG = 3'd1;
	localparam logic [2:0] FORM_IMM_RM  = 3'd2;
	localparam logic [2:0] FORM_ACC_MEM = 3'd3;
	localparam logic [2:0] FORM_IMM_ACC = 3'd4;
	localparam logic [2:0] FORM_REL     = 3'd5;

	// group-1 reg field values with their own op_kind
	localparam logic [2:0] GRP1_ADD = 3'd0;
	localparam logic [2:0] GRP1_SUB = 3'd5;
	localparam logic [2:0] GRP1_CMP = 3'd7;

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	// classification of one opcode (plus mod-reg-rm byte)
	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] form;
		logic       wide;
		logic       dir;
		logic       has_m;
		logic [3:0] cond;
		logic [1:0] dl;   // displacement bytes
		logic [1:0] il;   // immediate bytes
	} dec_t;

	// raw assembled instruction passed from front to back
	typedef struct packed {
		logic [7:0]  opcode;
		logic [7:0]  modrm;
		logic [15:0] disp;
		logic [15:0] imm;
		logic [2:0]  total;
	} raw_t;

	function automatic dec_t decode(input logic [7:0] op, input logic [7:0] modrm);
		dec_t       d;
		logic [1:0] md;
		logic [2:0] rm;
		logic [2:0] r;
		logic       w;
		md = modrm[7:6];
		r  = modrm[5:3];
		rm = modrm[2:0];
		w  = op[0];
		d      = '0;
		d.kind = KIND_UNKNOWN;
		priority if (op[7:2] == 6'b100010 || op[7:2] == 6'b000000 ||
		             op[7:2] == 6'b001010 || op[7:2] == 6'b001110) begin
			// reg/mem with reg
			priority if (op[7:2] == 6'b100010) d.kind = KIND_MOV;
			else if (op[7:2] == 6'b000000) d.kind = KIND_ADD;
			else if (op[7:2] == 6'b001010) d.kind = KIND_SUB;
			else d.kind = KIND_CMP;
			d.form  = FORM_RM_REG;
			d.wide  = w;
			d.dir   = op[1];
			d.has_m = 1'b1;
		end else if (op[7:4] == 4'b1011) begin
			// mov immediate to register
			d.kind = KIND_MOV;
			d.form = FORM_IMM_REG;
			d.wide = op[3];
			d.il   = op[3] ? 2'd2 : 2'd1;
		end else if (op[7:1] == 7'b1100011) begin
			// mov immediate to reg/mem
			d.kind  = KIND_MOV;
			d.form  = FORM_IMM_RM;
			d.wide  = w;
			d.has_m = 1'b1;
			d.il    = w ? 2'd2 : 2'd1;
		end else if (op[7:2] == 6'b100000) begin
			// immediate group 80-83
			priority if (r == GRP1_ADD) d.kind = KIND_ADD;
			else if (r == GRP1_SUB) d.kind = KIND_SUB;
			else if (r == GRP1_CMP) d.kind = KIND_CMP;
			else d.kind = KIND_GRP1;
			d.form  = FORM_IMM_RM;
			d.wide  = w;
			d.has_m = 1'b1;
			d.il    = (w && !op[1]) ? 2'd2 : 2'd1;
		end else if (op[7:2] == 6'b101000) begin
			// accumulator and memory, always a 16-bit address
			d.kind = KIND_MOV;
			d.form = FORM_ACC_MEM;
			d.wide = w;
			d.dir  = op[1];
			d.dl   = 2'd2;
		end else if (op[7:1] == 7'b0000010 || op[7:1] == 7'b0010110 ||
		             op[7:1] == 7'b0011110) begin
			// immediate to accumulator
			priority if (op[7:1] == 7'b0000010) d.kind = KIND_ADD;
			else if (op[7:1] == 7'b0010110) d.kind = KIND_SUB;
			else d.kind = KIND_CMP;
			d.form = FORM_IMM_ACC;
			d.wide = w;
			d.il   = w ? 2'd2 : 2'd1;
		end else if (op[7:4] == 4'b0111) begin
			d.kind = KIND_JCC;
			d.form = FORM_REL;
			d.dl   = 2'd1;
			d.cond = op[3:0];
		end else if (op[7:2] == 6'b111000) begin
			d.kind = KIND_LOOP;
			d.form = FORM_REL;
			d.dl   = 2'd1;
			d.cond = {2'b00, op[1:0]};
		end else begin
			d.kind = KIND_UNKNOWN;
		end
		// displacement size from mod, direct address for mod 00 rm 110
		if (d.has_m) begin
			priority if (md == 2'd1) d.dl = 2'd1;
			else if (md == 2'd2) d.dl = 2'd2;
			else if (md == 2'd0 && rm == 3'd6) d.dl = 2'd2;
			else d.dl = 2'd0;
		end
		return d;
	endfunction

	// sign-extend a field of len bytes, zero when absent
	function automatic logic [15:0] sext_len(input logic [15:0] v, input logic [1:0] len);
		logic [15:0] res;
		unique case (len)
			2'd1:    res = {{8{v[7]}}, v[7:0]};
			2'd2:    res = v;
			default: res = 16'h0000;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

[rtl/xdec_byte_if.sv]
// Code byte channel: valid, ready and one instruction-stream byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface xdec_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink   (input valid, input code_byte, output ready);
endinterface

`default_nettype wire

[rtl/xdec_rec_if.sv]
// Decoded record channel: valid, ready and the decoded instruction fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface xdec_rec_if;
	logic              valid;
	logic              ready;
	logic [2:0]        op_kind;
	logic [2:0]        form;
	logic              wide;
	logic              direction;
	logic [1:0]        mod_field;
	logic [2:0]        reg_field;
	logic [2:0]        rm_field;
	logic signed [15:0] displacement;
	logic signed [15:0] immediate;
	logic [3:0]        condition;
	logic [2:0]        length;

	modport source (output valid, output op_kind, output form, output wide,
		output direction, output mod_field, output reg_field, output rm_field,
		output displacement, output immediate, output condition, output length,
		input ready);
	modport sink (input valid, input op_kind, input form, input wide,
		input direction, input mod_field, input reg_field, input rm_field,
		input displacement, input immediate, input condition, input length,
		output ready);
endinterface

`default_nettype wire

[rtl/xdec_front.sv]
// Front end: accepts code bytes and assembles opcode, mod-reg-rm,
// displacement and immediate bytes; pushes one raw record per instruction.
// Depends on xdec_pkg and xdec_byte_if.
`timescale 1ns / 1ps
`default_nettype none

module xdec_front
	import xdec_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	xdec_byte_if.sink   byte_ch,
	output logic        push_valid,
	input  wire logic   push_ready,
	output raw_t        push_data
);

	logic [7:0]  opcode_q, opcode_n;
	logic [7:0]  modrm_q, modrm_n;
	logic [15:0] disp_q, disp_n;
	logic [15:0] imm_q, imm_n;
	logic [2:0]  seen_q, seen_n;
	logic [2:0]  needed_q, needed_n;
	logic        accept;
	dec_t        d_cur, d_new, d_m;
	logic [2:0]  base, lim, idx, total;
	logic [15:0] lane;

	// a byte can always be taken while the queue has room
	assign byte_ch.ready = push_ready;
	assign accept        = byte_ch.valid && push_ready;

	assign d_cur = decode(opcode_q, modrm_q);
	assign d_new = decode(byte_ch.code_byte, 8'h00);
	assign d_m   = decode(opcode_q, byte_ch.code_byte);

	// assembly step for one accepted byte
	always_comb begin
		opcode_n   = opcode_q;
		modrm_n    = modrm_q;
		disp_n     = disp_q;
		imm_n      = imm_q;
		seen_n     = seen_q;
		needed_n   = needed_q;
		push_valid = 1'b0;
		total      = needed_q;
		base       = 3'd1 + {2'b00, d_cur.has_m};
		lim        = base + {1'b0, d_cur.dl};
		idx        = 3'd0;
		lane       = {8'h00, byte_ch.code_byte};
		if (accept) begin
			if (seen_q == 3'd0) begin
				// opcode byte
				opcode_n = byte_ch.code_byte;
				modrm_n  = 8'h00;
				disp_n   = 16'h0000;
				imm_n    = 16'h0000;
				seen_n   = 3'd1;
				if (d_new.has_m) begin
					needed_n = 3'd2;
				end else begin
					total = 3'd1 + {1'b0, d_new.dl} + {1'b0, d_new.il};
					if (total == 3'd1) push_valid = 1'b1;
					else needed_n = total;
				end
			end else if (d_cur.has_m && seen_q == 3'd1) begin
				// mod-reg-rm byte
				modrm_n = byte_ch.code_byte;
				seen_n  = 3'd2;
				total   = 3'd2 + {1'b0, d_m.dl} + {1'b0, d_m.il};
				if (total == 3'd2) push_valid = 1'b1;
				else needed_n = total;
			end else begin
				// displacement bytes first, then immediate bytes, low byte first
				if (seen_q < lim) begin
					idx    = seen_q - base;
					lane   = idx[0] ? {byte_ch.code_byte, 8'h00} : {8'h00, byte_ch.code_byte};
					disp_n = disp_q | lane;
				end else begin
					idx   = seen_q - lim;
					lane  = idx[0] ? {byte_ch.code_byte, 8'h00} : {8'h00, byte_ch.code_byte};
					imm_n = imm_q | lane;
				end
				seen_n = seen_q + 3'd1;
				total  = needed_q;
				if (seen_n >= needed_q) push_valid = 1'b1;
			end
			if (push_valid) begin
				seen_n   = 3'd0;
				needed_n = 3'd0;
			end
		end
	end

	always_comb begin
		push_data.opcode = opcode_n;
		push_data.modrm  = modrm_n;
		push_data.disp   = disp_n;
		push_data.imm    = imm_n;
		push_data.total  = total;
	end

	// assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q <= 8'h00;
			modrm_q  <= 8'h00;
			disp_q   <= 16'h0000;
			imm_q    <= 16'h0000;
			seen_q   <= 3'd0;
			needed_q <= 3'd0;
		end else begin
			opcode_q <= opcode_n;
			modrm_q  <= modrm_n;
			disp_q   <= disp_n;
			imm_q    <= imm_n;
			seen_q   <= seen_n;
			needed_q <= needed_n;
		end
	end

endmodule

`default_nettype wire

[rtl/xdec_queue.sv]
// Two-entry queue of raw instruction records between front and back end.
// Depends on xdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xdec_queue
	import xdec_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire raw_t  push_data,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output raw_t       pop_data
);

	raw_t                 mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push, do_pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

[rtl/xdec_back.sv]
// Back end: decodes raw records from the queue into output fields and holds
// them in the output register until taken.
// Depends on xdec_pkg and xdec_rec_if.
`timescale 1ns / 1ps
`default_nettype none

module xdec_back
	import xdec_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   pop_valid,
	output logic        pop_ready,
	input  wire raw_t   pop_data,
	xdec_rec_if.source  rec_ch
);

	dec_t        d;
	logic        valid_q;
	logic        load;
	logic [1:0]  mod_n;
	logic [2:0]  reg_n, rm_n;

	// take a record whenever the output register is free or being emptied
	assign pop_ready = !valid_q || rec_ch.ready;
	assign load      = pop_valid && pop_ready;
	assign d         = decode(pop_data.opcode, pop_data.modrm);

	// operand fields, zero when absent
	always_comb begin
		mod_n = 2'd0;
		reg_n = 3'd0;
		rm_n  = 3'd0;
		if (d.has_m) begin
			mod_n = pop_data.modrm[7:6];
			reg_n = pop_data.modrm[5:3];
			rm_n  = pop_data.modrm[2:0];
		end else if (d.form == FORM_IMM_REG && d.kind == KIND_MOV) begin
			reg_n = pop_data.opcode[2:0];
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			rec_ch.op_kind      <= d.kind;
			rec_ch.form         <= d.form;
			rec_ch.wide         <= d.wide;
			rec_ch.direction    <= d.dir;
			rec_ch.mod_field    <= mod_n;
			rec_ch.reg_field    <= reg_n;
			rec_ch.rm_field     <= rm_n;
			rec_ch.displacement <= $signed(sext_len(pop_data.disp, d.dl));
			rec_ch.immediate    <= $signed(sext_len(pop_data.imm, d.il));
			rec_ch.condition    <= d.cond;
			rec_ch.length       <= pop_data.total;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	assign rec_ch.valid = valid_q;

endmodule

`default_nettype wire

[rtl/x86_16bit_instruction_decoder.sv]
// Top level of the 8086 instruction decoder: front end, record queue, back end.
// Depends on xdec_pkg, xdec_byte_if, xdec_rec_if, xdec_front, xdec_queue, xdec_back.
//
//   channel   dir  payload                                     handshake
//   byte_ch   in   code_byte[7:0]                              valid/ready
//   rec_ch    out  op_kind form wide direction mod_field       valid/ready
//                  reg_field rm_field displacement immediate
//                  condition length
//
// One code byte is taken per cycle while the queue has room. The record of
// an instruction passes through the queue to the back output register.
// The two-entry queue lets the front keep assembling while the output stalls;
// byte_ch.ready drops only when that queue is full.
// Reset (arst_n low) clears the assembly state, the queue and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module x86_16bit_instruction_decoder
	import xdec_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	xdec_byte_if.sink   byte_ch,
	xdec_rec_if.source  rec_ch
);

	logic push_valid, push_ready;
	raw_t push_data;
	logic pop_valid, pop_ready;
	raw_t pop_data;

	xdec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_ch    (byte_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	xdec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	xdec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rec_ch    (rec_ch)
	);

	// front never completes an instruction into a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> push_ready)
		else $error("record pushed into full queue");

	// a record taken from the queue shows at the output next cycle
	a_pop_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> rec_ch.valid)
		else $error("popped record lost");

	// lengths stay in 1..6
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		rec_ch.valid |-> (rec_ch.length != 3'd0 && rec_ch.length != 3'd7))
		else $error("record length out of range");

	// unknown opcodes are single-byte records
	a_unknown_len: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_ch.valid && rec_ch.op_kind == KIND_UNKNOWN) |-> rec_ch.length == 3'd1)
		else $error("unknown record with length other than one");

endmodule

`default_nettype wire
